// File: rtl/bls_pkg.sv
// shared constants, payload types and helper functions of the bilinear sampler
package bls_pkg;

   // store geometry and fixed-point format
   localparam int MAX_COLS    = 256;
   localparam int MAX_ROWS    = 256;
   localparam int FRAC_BITS   = 8;

   localparam int PIXEL_BITS  = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int VALUE_BITS  = 16;
   localparam int CSR_BITS    = 9;
   localparam int CSR_INDEX_BITS = 1;

   localparam int COL_BITS    = $clog2(MAX_COLS);
   localparam int ROW_BITS    = $clog2(MAX_ROWS);
   localparam int ADDR_BITS   = $clog2(MAX_COLS * MAX_ROWS);
   // holds dimensions up to 4096, integer parts of a point and the 9-bit registers
   localparam int DIM_BITS    = 13;

   localparam int WGT_BITS    = FRAC_BITS + 1;
   localparam int H_BITS      = PIXEL_BITS + FRAC_BITS;
   localparam int V_BITS      = PIXEL_BITS + 2 * FRAC_BITS;
   localparam int ROUND_SHIFT = 2 * FRAC_BITS - 8;

   localparam logic [WGT_BITS-1:0] WGT_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [V_BITS-1:0] ROUND_HALF = V_BITS'((64'd1 << ROUND_SHIFT) >> 1);

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_BITS'(1);
   localparam logic [CSR_BITS-1:0] CSR_DIM_RESET = CSR_BITS'(256);

   // request kinds
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef struct packed {
      logic                   req_type;
      logic [7:0]             pixel_row;
      logic [7:0]             pixel_col;
      logic [PIXEL_BITS-1:0]  pixel_value;
      logic [SAMPLE_BITS-1:0] sample_x;
      logic [SAMPLE_BITS-1:0] sample_y;
   } req_word_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] sample_value;
      logic                  out_of_range;
   } rsp_word_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic [ADDR_BITS-1:0]  addr;
      logic [PIXEL_BITS-1:0] wdata;
   } ram_cmd_type;

   function automatic logic [ADDR_BITS-1:0] pixel_addr(input logic [DIM_BITS-1:0] row,
                                                       input logic [DIM_BITS-1:0] col);
      pixel_addr = ADDR_BITS'(row * MAX_COLS + col);
   endfunction

   // saturate a dimension register to 1 .. maxv
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CSR_BITS-1:0] v,
                                                     input int maxv);
      if (v == '0) begin
         clamp_dim = DIM_BITS'(1);
      end else if (DIM_BITS'(v) > DIM_BITS'(maxv)) begin
         clamp_dim = DIM_BITS'(maxv);
      end else begin
         clamp_dim = DIM_BITS'(v);
      end
   endfunction

   // reflect-101 neighbour to the right or below
   function automatic logic [DIM_BITS-1:0] mirror_next(input logic [DIM_BITS-1:0] i,
                                                       input logic [DIM_BITS-1:0] len);
      if (i + DIM_BITS'(1) < len) begin
         mirror_next = i + DIM_BITS'(1);
      end else if (len >= DIM_BITS'(2)) begin
         mirror_next = len - DIM_BITS'(2);
      end else begin
         mirror_next = '0;
      end
   endfunction

endpackage

// File: rtl/bls_pixel_ram.sv
// single-port pixel store with registered read data
module bls_pixel_ram (
   input  logic                           clock,
   input  bls_pkg::ram_cmd_type           cmd,
   output logic [bls_pkg::PIXEL_BITS-1:0] rdata
);

   logic [bls_pkg::PIXEL_BITS-1:0] mem [bls_pkg::MAX_ROWS * bls_pkg::MAX_COLS];
   logic [bls_pkg::PIXEL_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= mem[cmd.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bls_mac.sv
// shared multiply-accumulate unit of the blend sequencer
module bls_mac (
   input  logic [bls_pkg::H_BITS-1:0]   mul_a,
   input  logic [bls_pkg::WGT_BITS-1:0] mul_b,
   input  logic [bls_pkg::V_BITS-1:0]   acc,
   input  logic                         add_acc,
   output logic [bls_pkg::V_BITS-1:0]   result
);

   logic [bls_pkg::H_BITS+bls_pkg::WGT_BITS-1:0] product;

   always_comb begin
      product = (bls_pkg::H_BITS+bls_pkg::WGT_BITS)'(mul_a) *
                (bls_pkg::H_BITS+bls_pkg::WGT_BITS)'(mul_b);
      // blended values never exceed 255 * 2^(2*FRAC_BITS), so the sum fits
      result  = bls_pkg::V_BITS'(product) + (add_acc ? acc : '0);
   end

endmodule

// File: rtl/bilinear_sample_gray8.sv
// top level of the bilinear sampler of an 8-bit grayscale pixel store
//
//   channel   direction  handshake              word
//   req_      in         req_valid / req_ready  req_word_type: write pixel or sample point
//   rsp_      out        rsp_valid / rsp_ready  rsp_word_type: blended value, range flag
//   csr_      in         csr_wr_en              csr_index selects width or height
//
// a pixel write leaves the sequencer in ST_IDLE, so writes go in back to back while it is idle
// an in-range sample runs the blend steps and ST_DONE from accept to ready again: four reads from the
//   single-port store and six passes through the one shared multiply-accumulate unit
// an out-of-range sample goes straight from accept to ST_DONE, with no reads
// reset is synchronous; it restores width and height to 256, the store is not cleared
// a result waits in the output register; only the next sample's finish stalls on it
module bilinear_sample_gray8 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bls_pkg::req_word_type              req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bls_pkg::rsp_word_type              rsp_data,
   input  logic                               csr_wr_en,
   input  logic [bls_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bls_pkg::CSR_BITS-1:0]       csr_wdata
);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // steps of the blend: reads and multiply-accumulate passes
   localparam logic [2:0] STEP_RD00  = 3'd0;  // read top left
   localparam logic [2:0] STEP_MUL00 = 3'd1;  // h = p00*(S-a), read top right
   localparam logic [2:0] STEP_MAC01 = 3'd2;  // h += p01*a
   localparam logic [2:0] STEP_V0    = 3'd3;  // v = h0*(S-c), read bottom left
   localparam logic [2:0] STEP_MUL10 = 3'd4;  // h = p10*(S-a), read bottom right
   localparam logic [2:0] STEP_MAC11 = 3'd5;  // h += p11*a
   localparam logic [2:0] STEP_V1    = 3'd6;  // v += h1*c

   localparam int DB = bls_pkg::DIM_BITS;
   localparam int FB = bls_pkg::FRAC_BITS;

   // control registers
   logic [1:0]                   state_ff, state_in;
   logic [2:0]                   step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bls_pkg::CSR_BITS-1:0] width_ff, width_in;
   logic [bls_pkg::CSR_BITS-1:0] height_ff, height_in;

   // payload registers
   logic [bls_pkg::COL_BITS-1:0] x0_ff, x0_in, x1_ff, x1_in;
   logic [bls_pkg::ROW_BITS-1:0] y0_ff, y0_in, y1_ff, y1_in;
   logic [FB-1:0]                frac_x_ff, frac_x_in, frac_y_ff, frac_y_in;
   logic                         oor_ff, oor_in;
   logic [bls_pkg::H_BITS-1:0]   hacc_ff, hacc_in;
   logic [bls_pkg::V_BITS-1:0]   vacc_ff, vacc_in;
   bls_pkg::rsp_word_type        rsp_data_ff, rsp_data_in;

   // datapath wires
   logic                           req_fire;
   logic                           rsp_free;
   logic [DB-1:0]                  dim_w, dim_h, pt_x0, pt_y0;
   logic                           pt_oor;
   bls_pkg::ram_cmd_type           ram_cmd;
   logic [bls_pkg::PIXEL_BITS-1:0] ram_rdata;
   logic [DB-1:0]                  rd_row, rd_col;
   logic [bls_pkg::H_BITS-1:0]     mac_a;
   logic [bls_pkg::WGT_BITS-1:0]   mac_b;
   logic [bls_pkg::V_BITS-1:0]     mac_acc, mac_result, rounded;
   logic                           mac_add;
   logic [bls_pkg::WGT_BITS-1:0]   wx1, wy1;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // point decode against the saturated image size
   always_comb begin
      dim_w  = bls_pkg::clamp_dim(width_ff, bls_pkg::MAX_COLS);
      dim_h  = bls_pkg::clamp_dim(height_ff, bls_pkg::MAX_ROWS);
      pt_x0  = DB'(req_data.sample_x[bls_pkg::SAMPLE_BITS-1:FB]);
      pt_y0  = DB'(req_data.sample_y[bls_pkg::SAMPLE_BITS-1:FB]);
      pt_oor = (pt_x0 >= dim_w) || (pt_y0 >= dim_h);
   end

   // neighbour address for the current read step
   always_comb begin
      unique case (step_ff)
         STEP_RD00: begin
            rd_row = DB'(y0_ff);
            rd_col = DB'(x0_ff);
         end
         STEP_MUL00: begin
            rd_row = DB'(y0_ff);
            rd_col = DB'(x1_ff);
         end
         STEP_V0: begin
            rd_row = DB'(y1_ff);
            rd_col = DB'(x0_ff);
         end
         default: begin
            rd_row = DB'(y1_ff);
            rd_col = DB'(x1_ff);
         end
      endcase
   end

   // store port: a pixel write goes in on accept, sample reads come from the sequencer
   always_comb begin
      ram_cmd.wr_en = req_fire && (req_data.req_type == bls_pkg::REQ_WRITE) &&
                      (DB'(req_data.pixel_row) < DB'(bls_pkg::MAX_ROWS)) &&
                      (DB'(req_data.pixel_col) < DB'(bls_pkg::MAX_COLS));
      ram_cmd.rd_en = (state_ff == ST_RUN) &&
                      ((step_ff == STEP_RD00) || (step_ff == STEP_MUL00) ||
                       (step_ff == STEP_V0) || (step_ff == STEP_MUL10));
      ram_cmd.wdata = req_data.pixel_value;
      if (ram_cmd.wr_en) begin
         ram_cmd.addr = bls_pkg::pixel_addr(DB'(req_data.pixel_row), DB'(req_data.pixel_col));
      end else begin
         ram_cmd.addr = bls_pkg::pixel_addr(rd_row, rd_col);
      end
   end

   bls_pixel_ram u_ram (
      .clock (clock),
      .cmd   (ram_cmd),
      .rdata (ram_rdata)
   );

   // operand selection for the shared multiply-accumulate unit
   always_comb begin
      wx1     = bls_pkg::WGT_BITS'(frac_x_ff);
      wy1     = bls_pkg::WGT_BITS'(frac_y_ff);
      mac_a   = bls_pkg::H_BITS'(ram_rdata);
      mac_b   = bls_pkg::WGT_ONE - wx1;
      mac_acc = bls_pkg::V_BITS'(hacc_ff);
      mac_add = 1'b0;
      unique case (step_ff)
         STEP_MAC01, STEP_MAC11: begin
            mac_b   = wx1;
            mac_add = 1'b1;
         end
         STEP_V0: begin
            mac_a = hacc_ff;
            mac_b = bls_pkg::WGT_ONE - wy1;
         end
         STEP_V1: begin
            mac_a   = hacc_ff;
            mac_b   = wy1;
            mac_acc = vacc_ff;
            mac_add = 1'b1;
         end
         default: begin
         end
      endcase
   end

   bls_mac u_mac (
      .mul_a   (mac_a),
      .mul_b   (mac_b),
      .acc     (mac_acc),
      .add_acc (mac_add),
      .result  (mac_result)
   );

   // one half-up rounding of the exact blend down to Q8.8
   assign rounded = (vacc_ff + bls_pkg::ROUND_HALF) >> bls_pkg::ROUND_SHIFT;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      width_in     = width_ff;
      height_in    = height_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      frac_x_in    = frac_x_ff;
      frac_y_in    = frac_y_ff;
      oor_in       = oor_ff;
      hacc_in      = hacc_ff;
      vacc_in      = vacc_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            bls_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            bls_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.req_type == bls_pkg::REQ_SAMPLE)) begin
               x0_in     = bls_pkg::COL_BITS'(pt_x0);
               y0_in     = bls_pkg::ROW_BITS'(pt_y0);
               x1_in     = bls_pkg::COL_BITS'(bls_pkg::mirror_next(pt_x0, dim_w));
               y1_in     = bls_pkg::ROW_BITS'(bls_pkg::mirror_next(pt_y0, dim_h));
               frac_x_in = req_data.sample_x[FB-1:0];
               frac_y_in = req_data.sample_y[FB-1:0];
               oor_in    = pt_oor;
               step_in   = STEP_RD00;
               state_in  = pt_oor ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            unique case (step_ff)
               STEP_MUL00, STEP_MAC01, STEP_MUL10, STEP_MAC11: begin
                  hacc_in = bls_pkg::H_BITS'(mac_result);
               end
               STEP_V0, STEP_V1: begin
                  vacc_in = mac_result;
               end
               default: begin
               end
            endcase
            if (step_ff == STEP_V1) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_DONE: begin
            // hold the finished result until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (oor_ff) begin
                  rsp_data_in.sample_value = '0;
                  rsp_data_in.out_of_range = 1'b1;
               end else begin
                  rsp_data_in.sample_value = bls_pkg::VALUE_BITS'(rounded);
                  rsp_data_in.out_of_range = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_RD00;
         rsp_valid_ff <= 1'b0;
         width_ff     <= bls_pkg::CSR_DIM_RESET;
         height_ff    <= bls_pkg::CSR_DIM_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      frac_x_ff   <= frac_x_in;
      frac_y_ff   <= frac_y_in;
      oor_ff      <= oor_in;
      hacc_ff     <= hacc_in;
      vacc_ff     <= vacc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // an in-range sample starts the blend sequence on the next cycle
   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.req_type == bls_pkg::REQ_SAMPLE) && !pt_oor)
      |=> (state_ff == ST_RUN) && (step_ff == STEP_RD00))
      else $error("in-range sample did not start the blend");

   // a blended value never goes above 255.0
   a_value_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.sample_value <= 16'hFF00))
      else $error("blended value out of bound");

   // an out-of-range word carries a zero value
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.out_of_range) |-> (rsp_data_ff.sample_value == '0))
      else $error("out-of-range word with nonzero value");

   // the store never sees a read and a write together
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      ram_cmd.rd_en |-> !req_ready && !ram_cmd.wr_en)
      else $error("pixel store read during accept");

endmodule
